>>> design/nsf_pkg.sv
// Shared constants, types and decode functions for the NMEA sentence framer.
package nsf_pkg;

   // ASCII codes the framer reacts to
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_CR     = 8'h0D;

   // sentence kinds
   typedef logic [2:0] kind_type;
   localparam kind_type KIND_NONE = 3'd0;
   localparam kind_type KIND_GGA  = 3'd1;
   localparam kind_type KIND_RMC  = 3'd2;
   localparam kind_type KIND_GSA  = 3'd3;
   localparam kind_type KIND_GSV  = 3'd4;

   // header is six characters; five are stored, the last is the current byte
   localparam int unsigned HDR_LEN = 6;
   typedef logic [2:0] hdr_cnt_type;
   localparam hdr_cnt_type HDR_FULL = 3'd6;
   localparam hdr_cnt_type HDR_LAST = 3'd5;

   // checksum digit count; three marks bad checksum text
   typedef logic [1:0] sum_cnt_type;
   localparam sum_cnt_type SUM_TWO = 2'd2;
   localparam sum_cnt_type SUM_BAD = 2'd3;

   // hardware field index limit
   localparam int unsigned FIELD_MAX_HW = 31;

   // Decode talker and type of a full header; c5 must be a comma.
   function automatic kind_type match_header(input logic [7:0] c0, input logic [7:0] c1,
                                             input logic [7:0] c2, input logic [7:0] c3,
                                             input logic [7:0] c4, input logic [7:0] c5);
      logic     talker_ok;
      kind_type k;
      talker_ok = (c0 == "G") &&
                  ((c1 == "N") || (c1 == "P") || (c1 == "L") || (c1 == "A"));
      k = KIND_NONE;
      if (c2 == "G" && c3 == "G" && c4 == "A") k = KIND_GGA;
      if (c2 == "R" && c3 == "M" && c4 == "C") k = KIND_RMC;
      if (c2 == "G" && c3 == "S" && c4 == "A") k = KIND_GSA;
      if (c2 == "G" && c3 == "S" && c4 == "V") k = KIND_GSV;
      if (!talker_ok || c5 != CH_COMMA) k = KIND_NONE;
      return k;
   endfunction

   // Hex digit value in bits 3:0; bit 4 set for a non-hex byte.
   function automatic logic [4:0] hex_value(input logic [7:0] c);
      logic [4:0] h;
      h = 5'h10;
      if (c >= "0" && c <= "9") h = {1'b0, 4'(c - "0")};
      if (c >= "A" && c <= "F") h = {1'b0, 4'(c - "A" + 8'd10)};
      if (c >= "a" && c <= "f") h = {1'b0, 4'(c - "a" + 8'd10)};
      return h;
   endfunction

endpackage

>>> design/nmea_sentence_framer.sv
// NMEA sentence framer: header match, field tagging and checksum check.
//
//   channel   direction  handshake              payload
//   req       in         req_valid / req_ready  req_rx_byte
//   rsp       out        rsp_valid / rsp_ready  rsp_sentence_type .. rsp_computed_checksum
//
// One byte is taken per cycle while req_ready is high; its result appears in the
// output register in the cycle after the req transfer. Sentence state and the result
// register update in the same edge, so throughput is one byte per clock unless rsp stalls.
// req_ready is high whenever the result register is empty or being drained.
// Synchronous reset clears sentence state and the output valid.
module nmea_sentence_framer
   import nsf_pkg::*;
#(
   parameter int unsigned MAX_FIELD_INDEX = 31
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [2:0] rsp_sentence_type,
   output logic [4:0] rsp_field_index,
   output logic       rsp_data_valid,
   output logic [7:0] rsp_data_char,
   output logic       rsp_field_end,
   output logic       rsp_sentence_end,
   output logic       rsp_checksum_ok,
   output logic [7:0] rsp_computed_checksum
);

   localparam int unsigned FIELD_LIMIT_INT =
      (MAX_FIELD_INDEX > FIELD_MAX_HW) ? FIELD_MAX_HW : MAX_FIELD_INDEX;
   localparam logic [4:0] FIELD_LIMIT = 5'(FIELD_LIMIT_INT);

   // sentence state
   logic        in_sentence_ff, in_sentence_in;
   logic        in_checksum_ff, in_checksum_in;
   logic [7:0]  running_xor_ff, running_xor_in;
   hdr_cnt_type header_count_ff, header_count_in;
   kind_type    sentence_kind_ff, sentence_kind_in;
   logic [4:0]  field_counter_ff, field_counter_in;
   logic [7:0]  received_sum_ff, received_sum_in;
   sum_cnt_type sum_digits_ff, sum_digits_in;
   logic [7:0]  header_chars_ff [HDR_LEN-1];
   logic        hdr_we;

   // result register
   logic        rsp_valid_ff, rsp_valid_in;
   kind_type    type_ff, type_in;
   logic [4:0]  index_ff, index_in;
   logic        dv_ff, dv_in;
   logic [7:0]  char_ff;
   logic        fe_ff, fe_in;
   logic        se_ff, se_in;
   logic        ok_ff, ok_in;
   logic [7:0]  sum_out_ff;

   logic        req_xfer;
   logic [7:0]  c;
   logic [4:0]  hex;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_xfer  = req_valid && req_ready;
   assign c         = req_rx_byte;
   assign hex       = hex_value(c);

   // next sentence state and result for the incoming byte
   always_comb begin
      in_sentence_in   = in_sentence_ff;
      in_checksum_in   = in_checksum_ff;
      running_xor_in   = running_xor_ff;
      header_count_in  = header_count_ff;
      sentence_kind_in = sentence_kind_ff;
      field_counter_in = field_counter_ff;
      received_sum_in  = received_sum_ff;
      sum_digits_in    = sum_digits_ff;
      hdr_we           = 1'b0;
      type_in          = KIND_NONE;
      index_in         = '0;
      dv_in            = 1'b0;
      fe_in            = 1'b0;
      se_in            = 1'b0;
      ok_in            = 1'b0;
      if (c == CH_DOLLAR) begin
         // start of sentence clears everything
         in_sentence_in   = 1'b1;
         in_checksum_in   = 1'b0;
         running_xor_in   = '0;
         header_count_in  = '0;
         sentence_kind_in = KIND_NONE;
         field_counter_in = '0;
         received_sum_in  = '0;
         sum_digits_in    = '0;
      end else if (in_sentence_ff && !in_checksum_ff) begin
         type_in  = sentence_kind_ff;
         index_in = field_counter_ff;
         if (c == CH_STAR) begin
            in_checksum_in  = 1'b1;
            received_sum_in = '0;
            sum_digits_in   = '0;
            header_count_in = HDR_FULL;
            fe_in           = (sentence_kind_ff != KIND_NONE);
         end else begin
            running_xor_in = running_xor_ff ^ c;
            if (header_count_ff < HDR_FULL) begin
               header_count_in = header_count_ff + 3'd1;
               hdr_we          = (header_count_ff < HDR_LAST);
               if (header_count_ff == HDR_LAST) begin
                  sentence_kind_in = match_header(header_chars_ff[0], header_chars_ff[1],
                                                  header_chars_ff[2], header_chars_ff[3],
                                                  header_chars_ff[4], c);
               end
               type_in = sentence_kind_in;
            end else if (sentence_kind_ff != KIND_NONE) begin
               if (c == CH_COMMA) begin
                  fe_in = 1'b1;
                  if (field_counter_ff < FIELD_LIMIT) begin
                     field_counter_in = field_counter_ff + 5'd1;
                  end
               end else begin
                  dv_in = 1'b1;
               end
            end
         end
      end else if (in_sentence_ff) begin
         // checksum digits after the star
         type_in  = sentence_kind_ff;
         index_in = field_counter_ff;
         if (c == CH_CR) begin
            se_in          = 1'b1;
            ok_in          = (sum_digits_ff == SUM_TWO) && (received_sum_ff == running_xor_ff);
            in_sentence_in = 1'b0;
            in_checksum_in = 1'b0;
         end else if (!hex[4] && sum_digits_ff < SUM_TWO) begin
            received_sum_in = {received_sum_ff[3:0], hex[3:0]};
            sum_digits_in   = sum_digits_ff + 2'd1;
         end else begin
            sum_digits_in = SUM_BAD;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_sentence_ff   <= 1'b0;
         in_checksum_ff   <= 1'b0;
         running_xor_ff   <= '0;
         header_count_ff  <= '0;
         sentence_kind_ff <= KIND_NONE;
         field_counter_ff <= '0;
         received_sum_ff  <= '0;
         sum_digits_ff    <= '0;
      end else if (req_xfer) begin
         in_sentence_ff   <= in_sentence_in;
         in_checksum_ff   <= in_checksum_in;
         running_xor_ff   <= running_xor_in;
         header_count_ff  <= header_count_in;
         sentence_kind_ff <= sentence_kind_in;
         field_counter_ff <= field_counter_in;
         received_sum_ff  <= received_sum_in;
         sum_digits_ff    <= sum_digits_in;
      end
   end

   // header character store, written at the current header position
   always_ff @(posedge clock) begin
      if (req_xfer && hdr_we) begin
         header_chars_ff[header_count_ff] <= c;
      end
   end

   // output valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_xfer) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // output payload, loaded on each req transfer
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         type_ff    <= type_in;
         index_ff   <= index_in;
         dv_ff      <= dv_in;
         char_ff    <= c;
         fe_ff      <= fe_in;
         se_ff      <= se_in;
         ok_ff      <= ok_in;
         sum_out_ff <= running_xor_in;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_sentence_type     = type_ff;
   assign rsp_field_index       = index_ff;
   assign rsp_data_valid        = dv_ff;
   assign rsp_data_char         = char_ff;
   assign rsp_field_end         = fe_ff;
   assign rsp_sentence_end      = se_ff;
   assign rsp_checksum_ok       = ok_ff;
   assign rsp_computed_checksum = sum_out_ff;

endmodule

>>> design/nsf_checker.sv
// Port-level assertions for the NMEA sentence framer, bound to the framer module.
module nsf_checker
   import nsf_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic [7:0] req_rx_byte,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [2:0] rsp_sentence_type,
   input logic [4:0] rsp_field_index,
   input logic       rsp_data_valid,
   input logic [7:0] rsp_data_char,
   input logic       rsp_field_end,
   input logic       rsp_sentence_end,
   input logic       rsp_checksum_ok,
   input logic [7:0] rsp_computed_checksum
);

   // a good checksum is only reported at the end of a sentence
   a_ok_needs_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_checksum_ok |-> rsp_sentence_end)
      else $error("checksum_ok without sentence_end");

   // data, field end and sentence end are mutually exclusive
   a_flags_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot0({rsp_data_valid, rsp_field_end, rsp_sentence_end}))
      else $error("data_valid, field_end and sentence_end overlap");

   // data and field ends only come from recognized sentences
   a_recognized: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data_valid || rsp_field_end) |-> rsp_sentence_type != KIND_NONE)
      else $error("field activity in an unrecognized sentence");

   // a stalled result holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data_char) &&
                                  $stable(rsp_computed_checksum) && $stable(rsp_field_index))
      else $error("stalled result changed");

   // each req transfer shows up as a result that echoes its byte
   a_req_echo: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid && rsp_data_char == $past(req_rx_byte))
      else $error("req transfer not echoed in the next result");

endmodule

bind nmea_sentence_framer nsf_checker u_nsf_checker (.*);

>>> tb/tb_nmea_sentence_framer.sv
// Self-checking testbench for the NMEA sentence framer: byte stimulus, prediction and checks.
module tb_nmea_sentence_framer
   import nsf_pkg::*;
;

   localparam int unsigned FIELD_LIMIT = 31;
   localparam int STIM_ITEMS   = 1200;
   localparam int TAIL_ITEMS   = 200;
   localparam int DRAIN_CYCLES = 8;
   localparam int CYCLE_LIMIT  = 400000;

   // how a generated sentence ends after its body
   typedef enum int {
      TAIL_GOOD,
      TAIL_GOOD_LOWER,
      TAIL_WRONG,
      TAIL_ONE_DIGIT,
      TAIL_NO_DIGITS,
      TAIL_THREE_DIGITS,
      TAIL_NON_HEX,
      TAIL_TWO_STARS,
      TAIL_OPEN,
      TAIL_NO_STAR
   } tail_kind_type;

   // one result, packed in port order
   typedef struct packed {
      kind_type   sentence_type;
      logic [4:0] field_index;
      logic       data_valid;
      logic [7:0] data_char;
      logic       field_end;
      logic       sentence_end;
      logic       checksum_ok;
      logic [7:0] computed_checksum;
   } frame_rsp_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_rx_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [2:0] rsp_sentence_type;
   logic [4:0] rsp_field_index;
   logic       rsp_data_valid;
   logic [7:0] rsp_data_char;
   logic       rsp_field_end;
   logic       rsp_sentence_end;
   logic       rsp_checksum_ok;
   logic [7:0] rsp_computed_checksum;

   nmea_sentence_framer #(
      .MAX_FIELD_INDEX(FIELD_LIMIT)
   ) uut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_rx_byte           (req_rx_byte),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_sentence_type     (rsp_sentence_type),
      .rsp_field_index       (rsp_field_index),
      .rsp_data_valid        (rsp_data_valid),
      .rsp_data_char         (rsp_data_char),
      .rsp_field_end         (rsp_field_end),
      .rsp_sentence_end      (rsp_sentence_end),
      .rsp_checksum_ok       (rsp_checksum_ok),
      .rsp_computed_checksum (rsp_computed_checksum)
   );

   always #4 clock = ~clock;

   // stimulus and scoreboard storage
   logic [7:0] pending_bytes [$];
   logic [7:0] body_bytes [$];
   frame_rsp_type expected_rsp_q [$];
   int         frame_items = 0;
   int         pending_total = 0;
   int         bytes_accepted = 0;
   int         fail_count = 0;
   int         cycle_count = 0;
   int         req_gap = 0;
   int         rsp_stall = 0;
   bit         req_accepted = 1'b0;

   string talker_text [4] = '{"GN", "GP", "GL", "GA"};
   string kind_text [4]   = '{"GGA", "RMC", "GSA", "GSV"};

   // predicted framer state
   logic        fr_in_sentence = 1'b0;
   logic        fr_in_sum = 1'b0;
   logic [7:0]  fr_xor = 8'h00;
   logic [7:0]  fr_hdr [HDR_LEN];
   hdr_cnt_type fr_hdr_cnt = '0;
   kind_type    fr_kind = KIND_NONE;
   logic [4:0]  fr_field = '0;
   logic [7:0]  fr_sum = 8'h00;
   sum_cnt_type fr_digits = '0;

   // hex digit value, bit 4 flags a non-hex byte
   function automatic logic [4:0] nibble_of(input logic [7:0] c);
      if (c >= "0" && c <= "9")
         return {1'b0, c[3:0]};
      if ((c >= "A" && c <= "F") || (c >= "a" && c <= "f"))
         return {1'b0, c[3:0] + 4'd9};
      return 5'h10;
   endfunction

   // sentence kind of the six collected header characters
   function automatic kind_type header_kind();
      kind_type k;
      logic     talker_ok;
      talker_ok = (fr_hdr[0] == "G") && (fr_hdr[1] == "N" || fr_hdr[1] == "P" ||
                                         fr_hdr[1] == "L" || fr_hdr[1] == "A");
      case ({fr_hdr[2], fr_hdr[3], fr_hdr[4]})
         "GGA":   k = KIND_GGA;
         "RMC":   k = KIND_RMC;
         "GSA":   k = KIND_GSA;
         "GSV":   k = KIND_GSV;
         default: k = KIND_NONE;
      endcase
      if (!talker_ok || fr_hdr[5] != CH_COMMA)
         k = KIND_NONE;
      return k;
   endfunction

   // advance the predicted state by one byte and return its result
   function automatic frame_rsp_type frame_byte(input logic [7:0] c);
      frame_rsp_type r;
      logic [4:0] h;
      r = '0;
      r.data_char = c;
      if (c == CH_DOLLAR) begin
         // a dollar sign restarts everything
         fr_in_sentence = 1'b1;
         fr_in_sum = 1'b0;
         fr_xor = 8'h00;
         fr_hdr_cnt = '0;
         fr_kind = KIND_NONE;
         fr_field = '0;
         fr_sum = 8'h00;
         fr_digits = '0;
      end else if (fr_in_sentence && !fr_in_sum) begin
         r.sentence_type = fr_kind;
         r.field_index = fr_field;
         if (c == CH_STAR) begin
            fr_in_sum = 1'b1;
            fr_sum = 8'h00;
            fr_digits = '0;
            fr_hdr_cnt = HDR_FULL;
            r.field_end = (fr_kind != KIND_NONE);
         end else begin
            fr_xor ^= c;
            if (fr_hdr_cnt < HDR_FULL) begin
               fr_hdr[fr_hdr_cnt] = c;
               fr_hdr_cnt++;
               if (fr_hdr_cnt == HDR_FULL)
                  fr_kind = header_kind();
               r.sentence_type = fr_kind;
            end else if (fr_kind != KIND_NONE) begin
               if (c == CH_COMMA) begin
                  r.field_end = 1'b1;
                  if (fr_field < FIELD_LIMIT)
                     fr_field++;
               end else begin
                  r.data_valid = 1'b1;
               end
            end
         end
      end else if (fr_in_sentence) begin
         // checksum text after the star
         r.sentence_type = fr_kind;
         r.field_index = fr_field;
         if (c == CH_CR) begin
            r.sentence_end = 1'b1;
            r.checksum_ok = (fr_digits == SUM_TWO) && (fr_sum == fr_xor);
            fr_in_sentence = 1'b0;
            fr_in_sum = 1'b0;
         end else begin
            h = nibble_of(c);
            if (!h[4] && fr_digits < SUM_TWO) begin
               fr_sum = {fr_sum[3:0], h[3:0]};
               fr_digits++;
            end else begin
               fr_digits = SUM_BAD;
            end
         end
      end
      r.computed_checksum = fr_xor;
      return r;
   endfunction

   // ---------------- stimulus helpers ----------------

   function automatic logic [7:0] hex_digit(input logic [3:0] n, input bit lower);
      if (n < 4'd10)
         return 8'("0") + 8'(n);
      return (lower ? 8'("a") : 8'("A")) + 8'(n) - 8'd10;
   endfunction

   // content byte of a data field: mostly printable, sometimes anything but '$', '*' and ','
   function automatic logic [7:0] field_char();
      string      plain;
      logic [7:0] b;
      int         pick;
      plain = "0123456789.ABCNSEWMabz-";
      pick = $urandom_range(0, 15);
      if (pick == 0) begin
         do
            b = 8'($urandom_range(0, 255));
         while (b == CH_DOLLAR || b == CH_STAR || b == CH_COMMA);
      end else if (pick == 1) begin
         b = CH_CR;
      end else begin
         b = plain[$urandom_range(0, plain.len() - 1)];
      end
      return b;
   endfunction

   task automatic push_frame(input logic [7:0] b);
      pending_bytes.push_back(b);
      frame_items++;
   endtask

   task automatic append_text(input string s);
      foreach (s[i])
         body_bytes.push_back(s[i]);
   endtask

   // '$', the body, then the chosen checksum ending
   task automatic emit_sentence(input tail_kind_type tail);
      logic [7:0] sum;
      logic [7:0] shown;
      logic [7:0] junk;
      logic [4:0] junk_nib;
      string      edge_chars;
      bit         lower;
      edge_chars = "/:@G`gZz";
      sum = 8'h00;
      push_frame(CH_DOLLAR);
      foreach (body_bytes[i]) begin
         push_frame(body_bytes[i]);
         sum ^= body_bytes[i];
      end
      if (tail == TAIL_NO_STAR)
         return;
      push_frame(CH_STAR);
      shown = (tail == TAIL_WRONG) ? (sum ^ 8'($urandom_range(1, 255))) : sum;
      lower = (tail == TAIL_GOOD_LOWER);
      case (tail)
         TAIL_NO_DIGITS: begin
         end
         TAIL_ONE_DIGIT: begin
            push_frame(hex_digit(shown[7:4], 1'b0));
         end
         TAIL_NON_HEX: begin
            if ($urandom_range(0, 1) == 0) begin
               junk = edge_chars[$urandom_range(0, edge_chars.len() - 1)];
            end else begin
               do begin
                  junk = 8'($urandom_range(0, 255));
                  junk_nib = nibble_of(junk);
               end while (!junk_nib[4] || junk == CH_CR || junk == CH_DOLLAR);
            end
            if ($urandom_range(0, 1) == 0) begin
               push_frame(junk);
               push_frame(hex_digit(shown[7:4], 1'b0));
            end else begin
               push_frame(hex_digit(shown[7:4], 1'b0));
               push_frame(junk);
            end
         end
         TAIL_TWO_STARS: begin
            push_frame(hex_digit(shown[7:4], 1'b0));
            push_frame(CH_STAR);
         end
         default: begin
            push_frame(hex_digit(shown[7:4], lower));
            push_frame(hex_digit(shown[3:0], lower));
            if (tail == TAIL_THREE_DIGITS)
               push_frame(hex_digit(4'($urandom_range(0, 15)), 1'b0));
         end
      endcase
      if (tail != TAIL_OPEN)
         push_frame(CH_CR);
   endtask

   // random sentence: mostly well formed with random content, some broken
   task automatic add_random_sentence();
      int            pick;
      int            nfields;
      int            keep;
      tail_kind_type tail;
      body_bytes.delete();
      pick = $urandom_range(0, 9);
      if (pick < 8) begin
         append_text(talker_text[pick % 4]);
      end else begin
         body_bytes.push_back((pick == 8) ? 8'("G") : 8'($urandom_range("A", "Z")));
         body_bytes.push_back(8'($urandom_range("A", "Z")));
      end
      pick = $urandom_range(0, 9);
      if (pick < 8) begin
         append_text(kind_text[pick % 4]);
      end else begin
         repeat (3)
            body_bytes.push_back(8'($urandom_range("A", "Z")));
      end
      body_bytes.push_back(($urandom_range(0, 11) == 0) ? field_char() : CH_COMMA);

      if ($urandom_range(0, 14) == 0) begin
         // short header, star comes early
         keep = $urandom_range(0, 5);
         while (body_bytes.size() > keep)
            void'(body_bytes.pop_back());
      end else begin
         nfields = ($urandom_range(0, 9) == 0) ? $urandom_range(34, 42) : $urandom_range(0, 12);
         for (int i = 0; i < nfields; i++) begin
            if (i > 0)
               body_bytes.push_back(CH_COMMA);
            repeat ($urandom_range(0, 5))
               body_bytes.push_back(field_char());
         end
      end

      pick = $urandom_range(0, 99);
      if (pick < 55)      tail = TAIL_GOOD;
      else if (pick < 65) tail = TAIL_GOOD_LOWER;
      else if (pick < 72) tail = TAIL_WRONG;
      else if (pick < 76) tail = TAIL_ONE_DIGIT;
      else if (pick < 80) tail = TAIL_NO_DIGITS;
      else if (pick < 84) tail = TAIL_THREE_DIGITS;
      else if (pick < 88) tail = TAIL_NON_HEX;
      else if (pick < 91) tail = TAIL_TWO_STARS;
      else if (pick < 95) tail = TAIL_OPEN;
      else                tail = TAIL_NO_STAR;
      emit_sentence(tail);
   endtask

   // idling is off near the end and in a periodic calm stretch
   function automatic bit idling_allowed();
      return (pending_bytes.size() > TAIL_ITEMS) && (cycle_count[9:7] != 3'd5);
   endfunction

   task automatic compare_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         fail_count++;
      end
   endtask

   // ---------------- driver and monitor ----------------

   // request side: next byte after a transfer, random gaps between bytes
   always @(negedge clock) begin : byte_driver
      if (!reset && (!req_valid || req_accepted)) begin
         if (req_gap == 0 && idling_allowed() && $urandom_range(0, 11) == 0)
            req_gap = $urandom_range(1, 11);
         if (req_gap != 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (pending_bytes.size() != 0) begin
            req_rx_byte <= pending_bytes.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result side: random stall bursts
   always @(negedge clock) begin : rsp_throttle
      if (rsp_stall == 0 && idling_allowed() && $urandom_range(0, 11) == 0)
         rsp_stall = $urandom_range(1, 11);
      if (rsp_stall != 0) begin
         rsp_stall--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // predict on each byte transfer, check each result transfer
   always @(posedge clock) begin : monitor
      frame_rsp_type got;
      frame_rsp_type want;
      if (reset) begin
         req_accepted = 1'b0;
      end else begin
         req_accepted = req_valid && req_ready;
         if (req_accepted) begin
            expected_rsp_q.push_back(frame_byte(req_rx_byte));
            bytes_accepted++;
         end
         if (rsp_valid && rsp_ready) begin
            got = {rsp_sentence_type, rsp_field_index, rsp_data_valid, rsp_data_char,
                   rsp_field_end, rsp_sentence_end, rsp_checksum_ok, rsp_computed_checksum};
            if (expected_rsp_q.size() == 0) begin
               $error("result transfer with no byte pending, data_char %0h", rsp_data_char);
               fail_count++;
            end else begin
               want = expected_rsp_q.pop_front();
               compare_field("sentence_type", want.sentence_type, got.sentence_type);
               compare_field("field_index", want.field_index, got.field_index);
               compare_field("data_valid", want.data_valid, got.data_valid);
               compare_field("data_char", want.data_char, got.data_char);
               compare_field("field_end", want.field_end, got.field_end);
               compare_field("sentence_end", want.sentence_end, got.sentence_end);
               compare_field("checksum_ok", want.checksum_ok, got.checksum_ok);
               compare_field("computed_checksum", want.computed_checksum,
                             got.computed_checksum);
            end
         end
      end
   end

   // run limit
   always @(posedge clock) begin : watchdog
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("nmea_sentence_framer test failed");
         $finish;
      end
   end

   // ---------------- stimulus and end of run ----------------

   initial begin : stimulus
      logic [7:0] b;
      // directed: idle bytes, short header without digits,
      // carriage return inside data, unknown talker with a third digit
      pending_bytes.push_back(8'h00);
      pending_bytes.push_back(8'hFF);
      body_bytes.delete();
      append_text("GA");
      emit_sentence(TAIL_NO_DIGITS);
      body_bytes.delete();
      append_text("GLGSV,\r");
      emit_sentence(TAIL_GOOD);
      body_bytes.delete();
      append_text("GQRMC,");
      emit_sentence(TAIL_THREE_DIGITS);

      // random sentences with noise bytes between them
      while (frame_items < STIM_ITEMS) begin
         repeat ($urandom_range(0, 3)) begin
            do
               b = 8'($urandom_range(0, 255));
            while (b == CH_DOLLAR);
            pending_bytes.push_back(b);
         end
         add_random_sentence();
      end
      pending_total = pending_bytes.size();

      repeat (9) @(negedge clock);
      reset <= 1'b0;

      while (bytes_accepted != pending_total || expected_rsp_q.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0)
         $display("nmea_sentence_framer test passed");
      else
         $display("nmea_sentence_framer test failed");
      $finish;
   end

endmodule

>>> files.f
design/nsf_pkg.sv
design/nmea_sentence_framer.sv
design/nsf_checker.sv
tb/tb_nmea_sentence_framer.sv
